/* hw/rtl/nps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nps_pkg
// shared constants for the nearest point search block: default sizes,
// fixed result field widths and operation codes
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int COORD_BITS_DEF  = 24;

    localparam int OP_W            = 2;
    localparam int IDX_OUT_W       = 10;
    localparam int DIST_OUT_W      = 26;
    localparam int OUT_TDATA_W     = 40;
    localparam int OUT_TUSER_W     = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

endpackage : nps_pkg
`default_nettype wire

/* hw/rtl/nearest_point_search_top.sv */
`default_nettype none
// append and clear are taken in idle; a query scans the stored points, drains
// the distance pipeline, takes the square root and loads the output, paced by
// the one-point-per-cycle memory read port and the one-bit-per-cycle root
// (input is not ready while a query runs, and a waiting result holds the
// output state); i_rst_n (synchronous) empties the store
// and clears the drop flag, memory is not cleared
// ----------------------------------------------------------------------------
// nearest_point_search_top
// stores 3d points and answers nearest-point queries with the index of the
// closest point and the integer square root of its squared distance
// ----------------------------------------------------------------------------
module nearest_point_search_top
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    // x_coord, y_coord, z_coord (lowest bit up), zero padded
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // nearest_index, distance (lowest bit up), zero padded
    output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // empty_res, overflow (lowest bit up)
    output      logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ENT_W  = 3 * COORD_BITS;
    localparam int AD_W   = COORD_BITS + 1;
    localparam int SQ_W   = 2 * AD_W;
    localparam int SUM_W  = 2 * COORD_BITS + 4;
    localparam int ROOT_W = SUM_W / 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_dropped;
    logic [CNT_W-1:0]  r_rd_cnt;

    logic [ENT_W-1:0]  r_mem [MAX_POINTS];
    logic [ENT_W-1:0]  r_rd_data;

    logic [2:0][COORD_BITS-1:0] r_q;
    logic [2:0][AD_W-1:0]       r_ad;
    logic [2:0][SQ_W-1:0]       r_sq;
    logic [SUM_W-1:0]           r_sum;
    logic [SUM_W-1:0]           r_best;
    logic                       r_have;

    logic r_v1, r_v2, r_v3, r_v4;
    logic [ADDR_W-1:0] r_idx1, r_idx2, r_idx3, r_idx4, r_best_idx;

    logic [SUM_W-1:0] r_rem, r_root, r_bit;
    logic             r_empty;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic [OUT_TUSER_W-1:0] r_m_user;

    logic              w_in_xfer;
    logic              w_issue;
    logic              w_out_free;
    logic              w_pipe_empty;
    logic [SUM_W-1:0]  w_trial;
    logic              w_ge;
    logic [16:0]       w_idx_ext;
    logic [31:0]       w_root_ext;
    logic [2:0][COORD_BITS-1:0] w_in_pt;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_issue       = (r_state == ST_SCAN) && (r_rd_cnt != r_count);
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_pipe_empty  = !r_v1 && !r_v2 && !r_v3 && !r_v4;
    assign w_trial       = r_root + r_bit;
    assign w_ge          = (r_rem >= w_trial);

    assign w_in_pt[0] = s_axis_tdata[COORD_BITS-1:0];
    assign w_in_pt[1] = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_in_pt[2] = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];

    assign w_idx_ext  = 17'(r_best_idx);
    assign w_root_ext = 32'(r_root[ROOT_W-1:0]);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_m_valid <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            // the output state loads its own result when the register frees up
            if (r_m_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        unique case (s_axis_tuser)
                            OP_APPEND: begin
                                if (r_count < CNT_W'(MAX_POINTS)) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_dropped <= 1'b1;
                                end
                            end
                            OP_QUERY: begin
                                r_state <= (r_count == '0) ? ST_OUT : ST_SCAN;
                            end
                            OP_CLEAR: begin
                                r_count   <= '0;
                                r_dropped <= 1'b0;
                            end
                            OP_NONE: ;
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (!w_issue) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_pipe_empty) begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_bit == '0) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // point memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && (s_axis_tuser == OP_APPEND) && (r_count < CNT_W'(MAX_POINTS))) begin
            r_mem[r_count[ADDR_W-1:0]] <= {w_in_pt[2], w_in_pt[1], w_in_pt[0]};
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_cnt[ADDR_W-1:0]];
        end
    end

    // distance pipeline: diff, square, sum, compare
    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic signed [AD_W-1:0] w_d;
        logic signed [COORD_BITS-1:0] w_p;
        logic signed [COORD_BITS-1:0] w_qs;
        assign w_p  = r_rd_data[g*COORD_BITS +: COORD_BITS];
        assign w_qs = r_q[g];
        assign w_d  = AD_W'(w_qs) - AD_W'(w_p);
        always_ff @(posedge i_clk) begin
            r_ad[g] <= w_d[AD_W-1] ? AD_W'(-w_d) : AD_W'(w_d);
            r_sq[g] <= r_ad[g] * r_ad[g];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx1 <= r_rd_cnt[ADDR_W-1:0];
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_idx4 <= r_idx3;
        r_sum  <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);

        if (w_issue) begin
            r_rd_cnt <= r_rd_cnt + 1'b1;
        end

        // strict less-than in ascending order keeps the lowest index on ties
        if (r_v4 && (!r_have || (r_sum < r_best))) begin
            r_best     <= r_sum;
            r_best_idx <= r_idx4;
            r_have     <= 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && (s_axis_tuser == OP_QUERY)) begin
                    r_q        <= w_in_pt;
                    r_rd_cnt   <= '0;
                    r_have     <= 1'b0;
                    r_empty    <= (r_count == '0);
                    r_root     <= '0;
                    r_best_idx <= '0;
                end
            end
            ST_DRAIN: begin
                if (w_pipe_empty) begin
                    r_rem  <= r_best;
                    r_root <= '0;
                    r_bit  <= SUM_W'(1) << (SUM_W - 2);
                end
            end
            ST_SQRT: begin
                // one result bit per cycle, restoring square root
                if (r_bit != '0) begin
                    if (w_ge) begin
                        r_rem  <= r_rem - w_trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_m_data <= {4'b0, w_root_ext[DIST_OUT_W-1:0],
                                 w_idx_ext[IDX_OUT_W-1:0]};
                    r_m_user <= {r_dropped, r_empty};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule : nearest_point_search_top
`default_nettype wire

/* bench/nearest_point_search_top_test.sv */
// ----------------------------------------------------------------------------
// nearest_point_search_top_test
// loads point sets into the nearest point search block, queries them and
// checks every transfer on the result stream against a bit-true prediction
// of index, distance, empty and overflow, under random idling and stalls
// ----------------------------------------------------------------------------

localparam int NPS_CW     = nps_pkg::COORD_BITS_DEF;
localparam int NPS_POINTS = nps_pkg::MAX_POINTS_DEF;

typedef struct packed {
    logic [nps_pkg::IDX_OUT_W-1:0]  idx;
    logic [nps_pkg::DIST_OUT_W-1:0] distance;
    logic                           empty;
    logic                           ovf;
} nearest_result_t;

// mirror of the point store and the results it owes
class nearest_result_book;
    logic signed [NPS_CW-1:0] store_x [NPS_POINTS];
    logic signed [NPS_CW-1:0] store_y [NPS_POINTS];
    logic signed [NPS_CW-1:0] store_z [NPS_POINTS];
    int count;
    bit dropped;
    int errors;
    nearest_result_t due_results [$];

    function new();
        count = 0;
        dropped = 1'b0;
        errors = 0;
    endfunction

    function nearest_result_t closest_point(logic signed [NPS_CW-1:0] x,
                                            logic signed [NPS_CW-1:0] y,
                                            logic signed [NPS_CW-1:0] z);
        nearest_result_t r;
        longint unsigned best;
        longint unsigned len;
        longint unsigned t;
        longint dx;
        longint dy;
        longint dz;
        int best_k;
        logic [nps_pkg::DIST_OUT_W-1:0] root;
        r = '0;
        r.ovf = dropped;
        if (count == 0) begin
            r.empty = 1'b1;
            return r;
        end
        best = 0;
        best_k = 0;
        for (int k = 0; k < count; k++) begin
            dx = x - store_x[k];
            dy = y - store_y[k];
            dz = z - store_z[k];
            len = dx * dx + dy * dy + dz * dz;
            // strict less-than keeps the lowest index on a tie
            if (k == 0 || len < best) begin
                best = len;
                best_k = k;
            end
        end
        // floor square root, one result bit per step from the top
        root = '0;
        for (int b = nps_pkg::DIST_OUT_W - 1; b >= 0; b--) begin
            t = root;
            t = t | (64'd1 << b);
            if (t * t <= best)
                root = t[nps_pkg::DIST_OUT_W-1:0];
        end
        r.idx = best_k[nps_pkg::IDX_OUT_W-1:0];
        r.distance = root;
        return r;
    endfunction

    function void note_transfer(logic [nps_pkg::OP_W-1:0] op, logic [NPS_CW-1:0] x,
                                logic [NPS_CW-1:0] y, logic [NPS_CW-1:0] z);
        case (op)
            nps_pkg::OP_APPEND: begin
                if (count < NPS_POINTS) begin
                    store_x[count] = x;
                    store_y[count] = y;
                    store_z[count] = z;
                    count++;
                end else begin
                    dropped = 1'b1;
                end
            end
            nps_pkg::OP_CLEAR: begin
                count = 0;
                dropped = 1'b0;
            end
            nps_pkg::OP_QUERY: begin
                due_results.push_back(closest_point(x, y, z));
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [nps_pkg::OUT_TDATA_W-1:0] tdata,
                               logic [nps_pkg::OUT_TUSER_W-1:0] tuser);
        nearest_result_t got;
        nearest_result_t want;
        bit bad;
        got.idx = tdata[nps_pkg::IDX_OUT_W-1:0];
        got.distance = tdata[nps_pkg::IDX_OUT_W +: nps_pkg::DIST_OUT_W];
        got.empty = tuser[0];
        got.ovf = tuser[1];
        if (due_results.size() == 0) begin
            $display("%0t: result with none due: index %0d distance %0d empty %0b overflow %0b",
                     $time, got.idx, got.distance, got.empty, got.ovf);
            errors++;
            return;
        end
        want = due_results.pop_front();
        bad = 1'b0;
        if (got.idx !== want.idx) begin
            $display("%0t: nearest_index expected %0d actual %0d", $time, want.idx, got.idx);
            bad = 1'b1;
        end
        if (got.distance !== want.distance) begin
            $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                     got.distance);
            bad = 1'b1;
        end
        if (got.empty !== want.empty) begin
            $display("%0t: empty_res expected %0b actual %0b", $time, want.empty, got.empty);
            bad = 1'b1;
        end
        if (got.ovf !== want.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, got.ovf);
            bad = 1'b1;
        end
        if (tdata[nps_pkg::OUT_TDATA_W-1:nps_pkg::IDX_OUT_W+nps_pkg::DIST_OUT_W] !== '0) begin
            $display("%0t: tdata padding expected 0 actual %h", $time,
                     tdata[nps_pkg::OUT_TDATA_W-1:nps_pkg::IDX_OUT_W+nps_pkg::DIST_OUT_W]);
            bad = 1'b1;
        end
        if (bad)
            errors++;
    endfunction
endclass

module nearest_point_search_top_test;
    import nps_pkg::*;

    localparam int CW         = NPS_CW;
    localparam int IN_W       = ((3 * CW + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 60;

    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] UNIT = 1 << 12;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata = '0;    // x_coord, y_coord, z_coord
    logic [OP_W-1:0]        s_axis_tuser = OP_NONE; // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // nearest_index, distance
    logic [OUT_TUSER_W-1:0] m_axis_tuser;         // empty_res, overflow

    nearest_result_book results;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    nearest_point_search_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [CW-1:0] coord_value(int mode);
        logic [CW-1:0] v;
        case (mode)
            0, 1, 2, 3: v = $urandom();
            // coarse grid near the origin, many exact ties
            4, 5: v = $urandom_range(4) * UNIT - 2 * UNIT;
            6, 7: v = $urandom_range(4) * UNIT - 2 * UNIT + $urandom_range(15) - 8;
            8: begin
                case ($urandom_range(3))
                    0: v = CMIN;
                    1: v = CMAX;
                    2: v = '1;
                    default: v = '0;
                endcase
            end
            default: begin
                v = $urandom() >> $urandom_range(CW - 1);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CW-1:0] x,
                             input logic [CW-1:0] y, input logic [CW-1:0] z);
        logic [IN_W-1:0] word;
        word = '0;
        word[CW-1:0] = x;
        word[2*CW-1:CW] = y;
        word[3*CW-1:2*CW] = z;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        results.note_transfer(op, x, y, z);
    endtask

    task automatic random_item(output bit counted);
        logic [OP_W-1:0] op;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        int r;
        int mode;
        int k;
        r = $urandom_range(99);
        if (results.count >= 40 && $urandom_range(7) == 0)
            op = OP_CLEAR;
        else if (r < 4)
            op = OP_NONE;
        else if (r < 8)
            op = OP_CLEAR;
        else if (r < 55)
            op = OP_APPEND;
        else
            op = OP_QUERY;
        mode = $urandom_range(9);
        x = coord_value(mode);
        y = coord_value(mode);
        z = coord_value(mode);
        // queries close to a stored point exercise the running minimum
        if (op == OP_QUERY && results.count > 0 && $urandom_range(2) == 0) begin
            k = $urandom_range(results.count - 1);
            x = results.store_x[k] + $urandom_range(6) - 3;
            y = results.store_y[k] + $urandom_range(6) - 3;
            z = results.store_z[k] + $urandom_range(6) - 3;
        end
        send_item(op, x, y, z);
        counted = (op != OP_NONE);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (results.due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // result side: checks each transfer, then picks the next ready level
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                results.check_result(m_axis_tdata, m_axis_tuser);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // no transfer on either side for too long means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("** nearest_point_search_top: FAILED **");
            $finish;
        end
    end

    initial begin
        int done;
        bit counted;
        results = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, ties and the ignored code
        send_item(OP_QUERY, '0, '0, '0);
        send_item(OP_NONE, CMAX, CMIN, '1);
        send_item(OP_APPEND, CMIN, CMIN, CMIN);
        send_item(OP_QUERY, CMAX, CMAX, CMAX);
        send_item(OP_APPEND, CMAX, CMAX, CMAX);
        send_item(OP_APPEND, '0, '0, '0);
        send_item(OP_APPEND, '0, '0, '0);
        send_item(OP_QUERY, '0, '0, '0);
        send_item(OP_QUERY, CMAX, CMAX, CMAX);
        send_item(OP_QUERY, CMIN, CMAX, '0);
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_APPEND, UNIT, '0, '0);
        send_item(OP_APPEND, -UNIT, '0, '0);
        send_item(OP_APPEND, '0, UNIT, '0);
        send_item(OP_QUERY, '0, '0, '0);
        send_item(OP_QUERY, '0, '0, CMIN);
        send_item(OP_NONE, '0, '0, '0);
        send_item(OP_CLEAR, CMAX, CMAX, CMAX);
        send_item(OP_QUERY, UNIT, UNIT, UNIT);
        send_item(OP_APPEND, CMAX, CMIN, CMAX);
        send_item(OP_QUERY, CMIN, CMAX, CMIN);
        wait_results_drained();

        // long result-side hold-off while items keep coming
        hold_left = 400;
        done = 0;
        while (done < 30) begin
            random_item(counted);
            done += counted;
        end
        wait_results_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            done = 0;
            while (done < 125) begin
                random_item(counted);
                done += counted;
            end
            wait_results_drained();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (results.errors == 0 && results.due_results.size() == 0) begin
            $display("** nearest_point_search_top: PASSED **");
        end else begin
            $display("** nearest_point_search_top: FAILED **");
        end
        $finish;
    end

endmodule
